[src/lifo_stack_with_search_update_macros.svh]
// -----------------------------------------------------------------------------
// lifo_stack_with_search_update_macros.svh
// Assertion macros used by the port-level checker of the stack block.
// -----------------------------------------------------------------------------
`ifndef LIFO_STACK_WITH_SEARCH_UPDATE_MACROS_SVH
`define LIFO_STACK_WITH_SEARCH_UPDATE_MACROS_SVH

// Checked only outside reset.
`define LSSU_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("lssu assertion failed");

// Checked at every edge, reset included.
`define LSSU_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("lssu assertion failed");

`endif

[src/lssu_pkg.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// lssu_pkg
// Types and constants of the searchable stack: item formats, codes, cell control.
// -----------------------------------------------------------------------------
package lssu_pkg;

   localparam int DEPTH   = 16;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int DATA_W  = 32;
   localparam int OUT_CNT_W = 5;

   typedef enum logic [1:0] {
      REQ_PUSH   = 2'd0,
      REQ_POP    = 2'd1,
      REQ_SEARCH = 2'd2,
      REQ_UPDATE = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef struct packed {
      req_kind_type              req_type;
      logic signed [DATA_W-1:0]  operand_value;
      logic signed [DATA_W-1:0]  replacement_value;
   } req_item_type;

   typedef struct packed {
      status_type                status;
      logic signed [DATA_W-1:0]  result_value;
      logic [OUT_CNT_W-1:0]      entry_count;
   } rsp_item_type;

   // Broadcast to every cell for one item.
   typedef struct packed {
      logic               push;
      logic               pop;
      logic               update;
      logic [DATA_W-1:0]  key;
      logic [DATA_W-1:0]  rep;
   } cell_ctrl_type;

endpackage

[src/lssu_cell.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// lssu_cell
// One stack slot: shifts with its neighbors, compares against the key and
// takes the replacement when it holds the match nearest the top.
// -----------------------------------------------------------------------------
module lssu_cell
   import lssu_pkg::*;
(
   input  logic               clock,
   input  cell_ctrl_type      ctrl,
   input  logic               occupied,
   input  logic [DATA_W-1:0]  upper_value,
   input  logic [DATA_W-1:0]  lower_value,
   input  logic               hit_above,
   output logic               hit_below,
   output logic [DATA_W-1:0]  value
);

   logic [DATA_W-1:0] value_ff;
   logic [DATA_W-1:0] value_in;
   logic              match;

   assign match     = occupied && (value_ff == ctrl.key);
   assign hit_below = hit_above | match;
   assign value     = value_ff;

   always_comb begin
      value_in = value_ff;
      if (ctrl.push) begin
         value_in = upper_value;
      end else if (ctrl.pop) begin
         value_in = lower_value;
      end else if (ctrl.update && match && !hit_above) begin
         value_in = ctrl.rep;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

[src/lifo_stack_with_search_update.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// lifo_stack_with_search_update
// Bounded LIFO of signed 32-bit values with search and first-match update,
// built as a row of cells with the top of the stack in cell 0.
// -----------------------------------------------------------------------------
//  channel  ports                            direction  payload
//  request  req_valid, req_stall, req_item   in         req_item_type
//  result   rsp_valid, rsp_stall, rsp_item   out        rsp_item_type
//
//  One item per cycle when not stalled: cells shift or compare in the accepting
//  cycle and the result sits in the output register from the next cycle on.
//  The match search ripples through the cell row, DEPTH cells long.
//  Reset empties the stack and drops any waiting result; cell data is not cleared.
//  A stalled result holds the output register and stalls the request side.
// -----------------------------------------------------------------------------
module lifo_stack_with_search_update
   import lssu_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  req_item_type  req_item,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rsp_item_type  rsp_item
);

   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   rsp_item_type       rsp_item_ff;
   rsp_item_type       rsp_item_in;

   logic               accept;
   logic               is_full;
   logic               is_empty;
   logic               found;
   cell_ctrl_type      ctrl;

   logic [DATA_W-1:0]  cell_value [DEPTH];
   logic [DATA_W-1:0]  up_data    [DEPTH];
   logic [DATA_W-1:0]  down_data  [DEPTH];
   logic [DEPTH:0]     hit_chain;
   logic [CNT_W+OUT_CNT_W-1:0] count_wide;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign is_full   = (count_ff == CNT_W'(DEPTH));
   assign is_empty  = (count_ff == '0);
   assign hit_chain[0] = 1'b0;
   assign found     = hit_chain[DEPTH];

   // Cell row
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_top
         assign up_data[i] = req_item.operand_value;
      end else begin : g_mid
         assign up_data[i] = cell_value[i-1];
      end
      if (i == DEPTH - 1) begin : g_bottom
         assign down_data[i] = '0;
      end else begin : g_inner
         assign down_data[i] = cell_value[i+1];
      end

      lssu_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .occupied    (CNT_W'(i) < count_ff),
         .upper_value (up_data[i]),
         .lower_value (down_data[i]),
         .hit_above   (hit_chain[i]),
         .hit_below   (hit_chain[i+1]),
         .value       (cell_value[i])
      );
   end

   always_comb begin
      ctrl.push   = 1'b0;
      ctrl.pop    = 1'b0;
      ctrl.update = 1'b0;
      ctrl.key    = req_item.operand_value;
      ctrl.rep    = req_item.replacement_value;
      count_in    = count_ff;
      rsp_item_in.status       = ST_OK;
      rsp_item_in.result_value = '0;
      unique case (req_item.req_type)
         REQ_PUSH: begin
            if (is_full) begin
               rsp_item_in.status = ST_FULL;
            end else begin
               ctrl.push = accept;
               count_in  = count_ff + CNT_W'(1);
            end
         end
         REQ_POP: begin
            if (is_empty) begin
               rsp_item_in.status = ST_EMPTY;
            end else begin
               ctrl.pop = accept;
               count_in = count_ff - CNT_W'(1);
               rsp_item_in.result_value = cell_value[0];
            end
         end
         REQ_SEARCH: begin
            if (!found) begin
               rsp_item_in.status = ST_NOT_FOUND;
            end
         end
         REQ_UPDATE: begin
            ctrl.update = accept;
            if (!found) begin
               rsp_item_in.status = ST_NOT_FOUND;
            end
         end
         default: begin
            rsp_item_in.status = ST_OK;
         end
      endcase
      count_wide = {{OUT_CNT_W{1'b0}}, count_in};
      rsp_item_in.entry_count = count_wide[OUT_CNT_W-1:0];
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

[src/lssu_checker.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// lssu_checker
// Port-level checks of the searchable stack, bound to the top level.
// -----------------------------------------------------------------------------
`include "lifo_stack_with_search_update_macros.svh"

module lssu_checker
   import lssu_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_stall,
   input  req_item_type  req_item,
   input  logic          rsp_valid,
   input  logic          rsp_stall,
   input  rsp_item_type  rsp_item
);

   logic rsp_full_seen;
   logic rsp_empty_seen;
   logic rsp_all_zero;

   assign rsp_full_seen  = rsp_valid && (rsp_item.status == ST_FULL);
   assign rsp_empty_seen = rsp_valid && (rsp_item.status == ST_EMPTY);
   assign rsp_all_zero   = (rsp_item.entry_count == '0) && (rsp_item.result_value == '0);

   `LSSU_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
   `LSSU_ASSERT(a_no_stall_when_free, !rsp_valid |-> !req_stall)
   `LSSU_ASSERT(a_full_count, rsp_full_seen |-> (rsp_item.entry_count == OUT_CNT_W'(DEPTH)))
   `LSSU_ASSERT(a_empty_pop, rsp_empty_seen |-> rsp_all_zero)
   // a cycle in reset leaves no result behind
   `LSSU_ASSERT_ALWAYS(a_reset_clears, reset |=> !rsp_valid)

endmodule

bind lifo_stack_with_search_update lssu_checker u_lssu_checker (.*);

[dv/lifo_stack_with_search_update_checker.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// lifo_stack_with_search_update_checker
// Watches both channels of the searchable stack, keeps a shadow copy of the
// stack, works out the result of every accepted request and compares it field
// by field with the results the block hands out, in order.
// -----------------------------------------------------------------------------
module lifo_stack_with_search_update_checker
   import lssu_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_stall,
   input  req_item_type  req_item,
   input  logic          rsp_valid,
   input  logic          rsp_stall,
   input  rsp_item_type  rsp_item,
   output int            fail_count,
   output int            pending_count,
   output int            full_refusals,
   output int            empty_pops
);

   logic [DATA_W-1:0] shadow_mem [DEPTH];
   int                shadow_fill;
   rsp_item_type      rsp_due_q [$];

   task automatic report_mismatch(input string msg);
      if (fail_count < 40) begin
         $display("MISMATCH at %0t ns: %s", $time, msg);
      end
      fail_count++;
   endtask

   // Applies one request to the shadow stack and returns the result it owes.
   function automatic rsp_item_type stack_step(input req_item_type it);
      rsp_item_type r;
      int hit;
      r.status       = ST_OK;
      r.result_value = '0;
      hit            = -1;
      // topmost match wins
      for (int i = shadow_fill - 1; i >= 0; i--) begin
         if (hit < 0 && shadow_mem[i] == it.operand_value) hit = i;
      end
      case (it.req_type)
         REQ_PUSH: begin
            if (shadow_fill >= DEPTH) begin
               r.status = ST_FULL;
            end else begin
               shadow_mem[shadow_fill] = it.operand_value;
               shadow_fill++;
            end
         end
         REQ_POP: begin
            if (shadow_fill == 0) begin
               r.status = ST_EMPTY;
            end else begin
               shadow_fill--;
               r.result_value = shadow_mem[shadow_fill];
            end
         end
         REQ_SEARCH: begin
            if (hit < 0) r.status = ST_NOT_FOUND;
         end
         default: begin
            if (hit < 0) r.status = ST_NOT_FOUND;
            else shadow_mem[hit] = it.replacement_value;
         end
      endcase
      r.entry_count = OUT_CNT_W'(shadow_fill);
      return r;
   endfunction

   always @(posedge clock) begin : watch
      rsp_item_type due;
      if (reset) begin
         rsp_due_q.delete();
         shadow_fill = 0;
      end else begin
         // result at this edge belongs to an earlier request
         if (rsp_valid && !rsp_stall) begin
            if (rsp_due_q.size() == 0) begin
               report_mismatch("result item with nothing expected");
            end else begin
               due = rsp_due_q.pop_front();
               if (rsp_item.status !== due.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_item.status, due.status));
               if (rsp_item.result_value !== due.result_value)
                  report_mismatch($sformatf("result_value %0h, expected %0h",
                                            rsp_item.result_value, due.result_value));
               if (rsp_item.entry_count !== due.entry_count)
                  report_mismatch($sformatf("entry_count %0d, expected %0d",
                                            rsp_item.entry_count, due.entry_count));
            end
         end
         if (req_valid && !req_stall) begin
            due = stack_step(req_item);
            if (due.status == ST_FULL) full_refusals++;
            if (due.status == ST_EMPTY) empty_pops++;
            rsp_due_q.push_back(due);
         end
      end
      pending_count <= rsp_due_q.size();
   end

endmodule

[dv/tb_lifo_stack_with_search_update.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_lifo_stack_with_search_update
// Drives push, pop, search and update requests into the searchable stack:
// a directed opening over the corner cases, then phases that fill the stack
// to full and drain it to empty, with random idling on both channels, one
// long result hold-off and a mid-run drain of all results. Checking is done by the checker.
// -----------------------------------------------------------------------------
module tb_lifo_stack_with_search_update;
   import lssu_pkg::*;

   logic          clock     = 1'b0;
   logic          reset     = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   req_item_type  req_item  = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   rsp_item_type  rsp_item;

   int fail_count;
   int pending_count;
   int full_refusals;
   int empty_pops;

   bit quiet     = 1'b0;
   bit long_hold = 1'b0;
   int push_sent, pop_sent, search_sent, update_sent;
   logic [DATA_W-1:0] value_pool [6];

   lifo_stack_with_search_update dut (.*);

   lifo_stack_with_search_update_checker stack_monitor (.*);

   always #2 clock = ~clock;

   task automatic send_req(input req_kind_type kind, input logic [DATA_W-1:0] opv,
                           input logic [DATA_W-1:0] rep);
      req_item_type it;
      it.req_type          = kind;
      it.operand_value     = opv;
      it.replacement_value = rep;
      case (kind)
         REQ_PUSH:   push_sent++;
         REQ_POP:    pop_sent++;
         REQ_SEARCH: search_sent++;
         default:    update_sent++;
      endcase
      req_valid <= 1'b1;
      req_item  <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic idle_sender(input int n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // pending_count is registered, hence the edge before the first look
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   task automatic refill_pool();
      for (int i = 0; i < 6; i++) begin
         case ($urandom_range(0, 5))
            0:       value_pool[i] = 32'h8000_0000;
            1:       value_pool[i] = 32'h7fff_ffff;
            2:       value_pool[i] = 32'h0000_0000;
            3:       value_pool[i] = 32'hffff_ffff;
            default: value_pool[i] = $urandom();
         endcase
      end
   endtask

   // small pool keeps search and update hits frequent
   function automatic logic [DATA_W-1:0] pick_value();
      if ($urandom_range(0, 9) < 7) return value_pool[$urandom_range(0, 5)];
      return $urandom();
   endfunction

   task automatic random_item(input int push_pct, input int pop_pct);
      int r;
      req_kind_type kind;
      r = $urandom_range(0, 99);
      if (r < push_pct) kind = REQ_PUSH;
      else if (r < push_pct + pop_pct) kind = REQ_POP;
      else if (r < push_pct + pop_pct + (100 - push_pct - pop_pct) / 2) kind = REQ_SEARCH;
      else kind = REQ_UPDATE;
      send_req(kind, pick_value(), ($urandom_range(0, 1) == 0) ? pick_value() : $urandom());
   endtask

   // receiver: short random stall bursts, one long hold-off on request
   initial begin : receiver
      wait (!reset);
      @(posedge clock);
      forever begin
         if (long_hold) begin
            long_hold = 1'b0;
            rsp_stall <= 1'b1;
            repeat (40) @(posedge clock);
         end else if (quiet) begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else begin
            rsp_stall <= ($urandom_range(0, 2) == 0);
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // empty stack corners
      send_req(REQ_POP,    32'h0000_0005, 32'h0000_0000);
      send_req(REQ_SEARCH, 32'h0000_0005, 32'h0000_0000);
      send_req(REQ_UPDATE, 32'h0000_0005, 32'h0000_0006);
      // extremes, with a duplicate near the top
      send_req(REQ_PUSH,   32'h8000_0000, 32'hffff_ffff);
      send_req(REQ_PUSH,   32'h7fff_ffff, 32'h0000_0000);
      send_req(REQ_PUSH,   32'h0000_0000, 32'h8000_0000);
      send_req(REQ_PUSH,   32'hffff_ffff, 32'h7fff_ffff);
      send_req(REQ_PUSH,   32'h0000_0007, 32'h0000_0000);
      send_req(REQ_PUSH,   32'h7fff_ffff, 32'h0000_0000);
      send_req(REQ_SEARCH, 32'h8000_0000, 32'h0000_0000);
      send_req(REQ_SEARCH, 32'h1234_5678, 32'h0000_0000);
      // only the upper copy changes
      send_req(REQ_UPDATE, 32'h7fff_ffff, 32'h5555_5555);
      send_req(REQ_SEARCH, 32'h7fff_ffff, 32'h0000_0000);
      send_req(REQ_POP,    32'hffff_ffff, 32'hffff_ffff);
      send_req(REQ_POP,    32'h0000_0000, 32'h0000_0000);
      send_req(REQ_UPDATE, 32'h8000_0000, 32'haaaa_aaaa);
      send_req(REQ_POP,    32'h0000_0000, 32'h0000_0000);
      send_req(REQ_POP,    32'h0000_0000, 32'h0000_0000);
      send_req(REQ_POP,    32'h0000_0000, 32'h0000_0000);
      send_req(REQ_POP,    32'h0000_0000, 32'h0000_0000);
      send_req(REQ_POP,    32'h0000_0000, 32'h0000_0000);

      // alternating fill-up and drain-down phases
      for (int n = 0; n < 550; n++) begin
         if (n % 40 == 0) refill_pool();
         if (n == 150) long_hold = 1'b1;
         if (n == 300) drain_results();
         if (n == 490) quiet = 1'b1;
         if (!quiet && $urandom_range(0, 4) == 0) idle_sender($urandom_range(1, 4));
         if ((n / 40) % 2 == 0) random_item(60, 15);
         else random_item(15, 55);
      end

      drain_results();
      repeat (10) @(posedge clock);
      $display("Sent %0d push, %0d pop, %0d search and %0d update items.",
               push_sent, pop_sent, search_sent, update_sent);
      $display("Saw %0d pushes refused on a full stack and %0d pops on an empty one.",
               full_refusals, empty_pops);
      if (fail_count == 0) begin
         $display("tb_lifo_stack_with_search_update OK");
      end else begin
         $display("tb_lifo_stack_with_search_update NOT OK");
      end
      $finish;
   end

   initial begin : watchdog
      #400000;
      $display("Timeout with %0d results outstanding", pending_count);
      $display("tb_lifo_stack_with_search_update NOT OK");
      $finish;
   end

endmodule

[files.f]
+incdir+src
src/lssu_pkg.sv
src/lssu_cell.sv
src/lifo_stack_with_search_update.sv
src/lssu_checker.sv
dv/lifo_stack_with_search_update_checker.sv
dv/tb_lifo_stack_with_search_update.sv
